// ===== hdl/nhrt_pkg.sv =====
// Shared types and constants for the next-hop router table.
// Used by the front, queue, back end and top level.
package nhrt_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_REPORTS = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam logic [31:0] NEAR_RESET = 32'd10000;
  localparam logic [7:0] HOP_SKIP_A = 8'hbe;
  localparam logic [7:0] HOP_SKIP_B = 8'hbf;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_CLEANUP = 3'd3;
  localparam logic [2:0] OP_SWAP = 3'd4;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_NEAR = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [31:0] peer_id;
    logic peer_local;
    logic [7:0] hop_count;
    logic [31:0] latency_us;
    logic [31:0] now;
    logic coin;
    logic known_op;
  } cmd_t;

  typedef struct packed {
    logic flag;
    logic table_full;
    logic [31:0] removed_peer;
    logic last;
  } result_t;

  function automatic logic [7:0] hop_merge(input logic [7:0] old_h, input logic [7:0] new_h);
    logic [7:0] d;
    d = new_h - old_h;
    if (new_h > old_h && (d == HOP_SKIP_A || d == HOP_SKIP_B)) return old_h;
    return new_h;
  endfunction

endpackage

// ===== hdl/next_hop_router_table.sv =====
// Top level of the next-hop router table: config registers, front, back end.
// Depends on nhrt_pkg, nhrt_front, nhrt_back.
//
//  channel   direction  handshake         payload
//  input     in         valid / ready     opcode .. coin
//  result    out        out_valid / out_ready  flag table_full removed_peer last
//  config    in         cfg_we            cfg_index cfg_data
//
// Add, update, delete and swap walk the table; cleanup compacts it and then
// runs an insertion sort, all on the one back-end sequencer.
// A two-item queue lets the front accept while the back end works.
// rst is synchronous; the table content is meaningless until written.
// A stalled result holds the back end; input stalls only when the queue fills.
module next_hop_router_table #(
  parameter int ENTRIES = nhrt_pkg::ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [2:0] opcode,
  input  logic [31:0] peer_id,
  input  logic peer_local,
  input  logic [7:0] hop_count,
  input  logic [31:0] latency_us,
  input  logic [31:0] now,
  input  logic coin,
  output logic out_valid,
  input  logic out_ready,
  output logic flag,
  output logic table_full,
  output logic [31:0] removed_peer,
  output logic last,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import nhrt_pkg::*;

  logic [15:0] peer_timeout;
  logic [31:0] near_latency_limit;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_timeout <= TIMEOUT_RESET;
      near_latency_limit <= NEAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: peer_timeout <= cfg_data[15:0];
        CFG_NEAR: near_latency_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  nhrt_front u_front (
    .clk, .rst, .valid, .ready, .opcode, .peer_id, .peer_local, .hop_count,
    .latency_us, .now, .coin, .q_valid, .q_ready, .q_cmd
  );

  nhrt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .peer_timeout, .near_latency_limit,
    .out_valid, .out_ready, .out_res(res)
  );

  assign flag = res.flag;
  assign table_full = res.table_full;
  assign removed_peer = res.removed_peer;
  assign last = res.last;
endmodule

// ===== hdl/nhrt_front.sv =====
// Front end: accepts items, tags unused opcodes, pushes into the command queue.
// Depends on nhrt_pkg.
module nhrt_front (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [2:0] opcode,
  input  logic [31:0] peer_id,
  input  logic peer_local,
  input  logic [7:0] hop_count,
  input  logic [31:0] latency_us,
  input  logic [31:0] now,
  input  logic coin,
  output logic q_valid,
  input  logic q_ready,
  output nhrt_pkg::cmd_t q_cmd
);
  import nhrt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  cmd_t mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] fill;
  cmd_t cmd_in;
  logic push, pop;

  always_comb begin
    cmd_in.opcode = opcode;
    cmd_in.peer_id = peer_id;
    cmd_in.peer_local = peer_local;
    cmd_in.hop_count = hop_count;
    cmd_in.latency_us = latency_us;
    cmd_in.now = now;
    cmd_in.coin = coin;
    cmd_in.known_op = (opcode <= OP_SWAP);
  end

  assign ready = (fill != (PW+1)'(QUEUE_DEPTH));
  assign push = valid && ready;
  assign q_valid = (fill != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd_in;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

// ===== hdl/nhrt_back.sv =====
// Back end: table storage and a sequencer that walks it one entry a cycle, unless a cleanup report waits on the output.
// Depends on nhrt_pkg. Results wait in a pending slot, then an output register.
module nhrt_back #(
  parameter int ENTRIES = nhrt_pkg::ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  nhrt_pkg::cmd_t q_cmd,
  input  logic [15:0] peer_timeout,
  input  logic [31:0] near_latency_limit,
  output logic out_valid,
  input  logic out_ready,
  output nhrt_pkg::result_t out_res
);
  import nhrt_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIND = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_COMPACT = 4'd3;
  localparam logic [3:0] S_SORT = 4'd4;
  localparam logic [3:0] S_NEAR = 4'd5;
  localparam logic [3:0] S_ROTATE = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;

  // table, held in flops; each entry is also read at a fixed neighbor
  logic [31:0] e_peer [ENTRIES];
  logic e_local [ENTRIES];
  logic [7:0] e_hops [ENTRIES];
  logic [31:0] e_lat [ENTRIES];
  logic [31:0] e_seen [ENTRIES];
  logic [CW-1:0] count;

  logic [3:0] state;
  cmd_t cmd;
  logic [CW-1:0] idx, wr, lim;
  logic [CW-1:0] srt_i;
  logic [4:0] nrep;
  logic hit;
  logic [IW-1:0] hit_at;
  logic removed_any;
  logic swapped;
  logic [31:0] span_cut;
  logic can_exp;

  logic res_valid;
  result_t res;
  result_t pend;
  assign out_valid = res_valid;
  assign out_res = res;

  // entry views
  logic [IW-1:0] ix, ixm;
  assign ix = idx[IW-1:0];
  assign ixm = ix - IW'(1);

  logic ranks;
  always_comb begin
    if (e_hops[ix] != e_hops[ixm]) ranks = e_hops[ix] < e_hops[ixm];
    else if (e_lat[ix] != e_lat[ixm]) ranks = e_lat[ix] < e_lat[ixm];
    else ranks = e_seen[ix] > e_seen[ixm];
  end

  logic [31:0] ldiff;
  logic near_ok;
  always_comb begin
    ldiff = (e_lat[ix] > e_lat[0]) ? e_lat[ix] - e_lat[0] : e_lat[0] - e_lat[ix];
    near_ok = (e_hops[ix] <= e_hops[0]) && (ldiff <= near_latency_limit);
  end

  logic expired;
  assign expired = can_exp && !e_local[ix] && (e_seen[ix] <= span_cut);

  logic out_free, rep_hit, res_load;
  assign out_free = !res_valid || out_ready;
  assign rep_hit = (state == S_COMPACT) && (idx < count) && (cmd.opcode == OP_CLEANUP)
                   && expired && (nrep != 5'(MAX_REPORTS));
  assign res_load = ((state == S_EMIT) && out_free) || (rep_hit && nrep != '0 && out_free);

  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_load) res_valid <= 1'b1;
    else if (out_ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            idx <= '0;
            wr <= '0;
            hit <= 1'b0;
            nrep <= '0;
            removed_any <= 1'b0;
            swapped <= 1'b0;
            span_cut <= q_cmd.now - {15'd0, peer_timeout, 1'b0};
            can_exp <= q_cmd.now >= {15'd0, peer_timeout, 1'b0};
            if (!q_cmd.known_op) begin
              pend <= '{flag: 1'b0, table_full: 1'b0, removed_peer: '0, last: 1'b1};
              state <= S_EMIT;
            end else if (q_cmd.opcode == OP_CLEANUP || q_cmd.opcode == OP_DELETE)
              state <= S_COMPACT;
            else if (q_cmd.opcode == OP_SWAP) begin
              if (q_cmd.coin || count == '0) begin
                pend <= '{flag: 1'b0, table_full: 1'b0, removed_peer: '0, last: 1'b1};
                state <= S_EMIT;
              end else begin
                idx <= CW'(1);
                state <= S_NEAR;
              end
            end else state <= S_FIND;
          end
        end
        S_FIND: begin
          if (idx < count && e_peer[ix] == cmd.peer_id) begin
            hit <= 1'b1;
            hit_at <= ix;
            idx <= count;
          end else if (idx < count) idx <= idx + CW'(1);
          else begin
            if (hit) begin
              e_seen[hit_at] <= cmd.now;
              e_hops[hit_at] <= hop_merge(e_hops[hit_at], cmd.hop_count);
              if (cmd.opcode == OP_UPDATE) e_lat[hit_at] <= cmd.latency_us;
              pend <= '{flag: (cmd.opcode == OP_UPDATE), table_full: 1'b0,
                        removed_peer: '0, last: 1'b1};
              state <= S_EMIT;
            end else if (cmd.opcode == OP_UPDATE) begin
              pend <= '{flag: 1'b0, table_full: 1'b0, removed_peer: '0, last: 1'b1};
              state <= S_EMIT;
            end else if (count == FULL) begin
              pend <= '{flag: 1'b0, table_full: 1'b1, removed_peer: '0, last: 1'b1};
              state <= S_EMIT;
            end else begin
              idx <= count;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (idx != '0) begin
            e_peer[ix] <= e_peer[ixm];
            e_local[ix] <= e_local[ixm];
            e_hops[ix] <= e_hops[ixm];
            e_lat[ix] <= e_lat[ixm];
            e_seen[ix] <= e_seen[ixm];
            idx <= idx - CW'(1);
          end else begin
            e_peer[0] <= cmd.peer_id;
            e_local[0] <= cmd.peer_local;
            e_hops[0] <= cmd.hop_count;
            e_lat[0] <= '0;
            e_seen[0] <= cmd.now;
            count <= count + CW'(1);
            pend <= '{flag: 1'b1, table_full: 1'b0, removed_peer: '0, last: 1'b1};
            state <= S_EMIT;
          end
        end
        S_COMPACT: begin
          if (idx < count) begin
            if (cmd.opcode == OP_DELETE && e_peer[ix] == cmd.peer_id) begin
              removed_any <= 1'b1;
              idx <= idx + CW'(1);
            end else if (cmd.opcode == OP_CLEANUP && expired && nrep != 5'(MAX_REPORTS)) begin
              // reports trail by one so the final one can still be marked last
              if (nrep == '0 || out_free) begin
                if (nrep != '0) res <= pend;
                pend <= '{flag: 1'b1, table_full: 1'b0, removed_peer: e_peer[ix],
                          last: 1'b0};
                nrep <= nrep + 5'd1;
                removed_any <= 1'b1;
                idx <= idx + CW'(1);
              end
            end else begin
              if (wr != idx) begin
                e_peer[wr[IW-1:0]] <= e_peer[ix];
                e_local[wr[IW-1:0]] <= e_local[ix];
                e_hops[wr[IW-1:0]] <= e_hops[ix];
                e_lat[wr[IW-1:0]] <= e_lat[ix];
                e_seen[wr[IW-1:0]] <= e_seen[ix];
              end
              wr <= wr + CW'(1);
              idx <= idx + CW'(1);
            end
          end else begin
            count <= wr;
            if (cmd.opcode == OP_DELETE) begin
              pend <= '{flag: removed_any, table_full: 1'b0, removed_peer: '0, last: 1'b1};
              state <= S_EMIT;
            end else begin
              lim <= wr;
              srt_i <= CW'(1);
              idx <= CW'(1);
              state <= S_SORT;
            end
          end
        end
        S_SORT: begin
          // insertion sort, one compare-and-swap per cycle
          if (srt_i >= lim) begin
            if (removed_any) pend.last <= 1'b1;
            else pend <= '{flag: 1'b0, table_full: 1'b0, removed_peer: '0, last: 1'b1};
            state <= S_EMIT;
          end else if (idx != '0 && ranks) begin
            e_peer[ix] <= e_peer[ixm]; e_peer[ixm] <= e_peer[ix];
            e_local[ix] <= e_local[ixm]; e_local[ixm] <= e_local[ix];
            e_hops[ix] <= e_hops[ixm]; e_hops[ixm] <= e_hops[ix];
            e_lat[ix] <= e_lat[ixm]; e_lat[ixm] <= e_lat[ix];
            e_seen[ix] <= e_seen[ixm]; e_seen[ixm] <= e_seen[ix];
            idx <= idx - CW'(1);
          end else begin
            srt_i <= srt_i + CW'(1);
            idx <= srt_i + CW'(1);
          end
        end
        S_NEAR: begin
          if (idx < count && near_ok) idx <= idx + CW'(1);
          else begin
            lim <= idx - CW'(1);
            idx <= CW'(1);
            state <= S_ROTATE;
          end
        end
        S_ROTATE: begin
          if (idx <= lim) begin
            e_peer[ix] <= e_peer[ixm]; e_peer[ixm] <= e_peer[ix];
            e_local[ix] <= e_local[ixm]; e_local[ixm] <= e_local[ix];
            e_hops[ix] <= e_hops[ixm]; e_hops[ixm] <= e_hops[ix];
            e_lat[ix] <= e_lat[ixm]; e_lat[ixm] <= e_lat[ix];
            e_seen[ix] <= e_seen[ixm]; e_seen[ixm] <= e_seen[ix];
            swapped <= 1'b1;
            idx <= idx + CW'(1);
          end else begin
            pend <= '{flag: swapped, table_full: 1'b0, removed_peer: '0, last: 1'b1};
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res <= pend;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/next_hop_router_table_tb.sv =====
// Self-checking testbench for next_hop_router_table: directed and random items
// checked against an in-bench route table predictor. Depends on nhrt_pkg.
`timescale 1ns / 1ps

module next_hop_router_table_tb;
  import nhrt_pkg::*;

  localparam int NROUTES = 16;
  localparam int POOL = 20;
  localparam int SETTLE = 400;

  typedef struct {
    logic [31:0] peer;
    logic        loc_flag;
    logic [7:0]  hops;
    logic [31:0] lat;
    logic [31:0] seen;
  } route_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [2:0] opcode = '0;
  logic [31:0] peer_id = '0;
  logic peer_local = 1'b0;
  logic [7:0] hop_count = '0;
  logic [31:0] latency_us = '0;
  logic [31:0] now = '0;
  logic coin = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic flag, table_full, last;
  logic [31:0] removed_peer;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  next_hop_router_table dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  route_t routes[NROUTES];
  int route_cnt;
  logic [15:0] timeout_reg;
  logic [31:0] near_reg;
  result_t pending_results[$];
  int errors;
  int burst_left;
  logic [31:0] peer_pool[POOL];
  logic [31:0] clock_now;

  function automatic int find_route(logic [31:0] id);
    for (int i = 0; i < route_cnt; i++)
      if (routes[i].peer == id) return i;
    return -1;
  endfunction

  function automatic logic [7:0] merged_hops(logic [7:0] oh, logic [7:0] nh);
    logic [7:0] d;
    d = nh - oh;
    if (nh > oh && (d == HOP_SKIP_A || d == HOP_SKIP_B)) return oh;
    return nh;
  endfunction

  function automatic bit ranks_ahead(route_t a, route_t b);
    if (a.hops != b.hops) return a.hops < b.hops;
    if (a.lat != b.lat) return a.lat < b.lat;
    return a.seen > b.seen;
  endfunction

  function automatic void push_result(logic f, logic full, logic [31:0] p, logic l);
    result_t r;
    r.flag = f;
    r.table_full = full;
    r.removed_peer = p;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  task automatic predict_routes(logic [2:0] op, logic [31:0] id, logic loc,
                                logic [7:0] h, logic [31:0] lat, logic [31:0] t,
                                logic c);
    int f, w, n, near_n, j;
    logic [31:0] span, cut, d;
    bit can_exp;
    route_t tmp;
    f = find_route(id);
    case (op)
      OP_ADD: begin
        if (f >= 0) begin
          routes[f].seen = t;
          routes[f].hops = merged_hops(routes[f].hops, h);
          push_result(1'b0, 1'b0, '0, 1'b1);
        end else if (route_cnt >= NROUTES) begin
          push_result(1'b0, 1'b1, '0, 1'b1);
        end else begin
          for (int i = route_cnt; i > 0; i--) routes[i] = routes[i-1];
          routes[0] = '{id, loc, h, 32'd0, t};
          route_cnt++;
          push_result(1'b1, 1'b0, '0, 1'b1);
        end
      end
      OP_UPDATE: begin
        if (f >= 0) begin
          routes[f].seen = t;
          routes[f].hops = merged_hops(routes[f].hops, h);
          routes[f].lat = lat;
        end
        push_result(f >= 0, 1'b0, '0, 1'b1);
      end
      OP_DELETE: begin
        w = 0;
        for (int i = 0; i < route_cnt; i++)
          if (routes[i].peer != id) begin
            routes[w] = routes[i];
            w++;
          end
        push_result(w != route_cnt, 1'b0, '0, 1'b1);
        route_cnt = w;
      end
      OP_CLEANUP: begin
        span = 32'(timeout_reg) * 2;
        can_exp = t >= span;
        cut = t - span;
        w = 0;
        n = 0;
        for (int i = 0; i < route_cnt; i++) begin
          if (can_exp && !routes[i].loc_flag && routes[i].seen <= cut && n < MAX_REPORTS)
          begin
            push_result(1'b1, 1'b0, routes[i].peer, 1'b0);
            n++;
          end else begin
            routes[w] = routes[i];
            w++;
          end
        end
        route_cnt = w;
        for (int i = 1; i < route_cnt; i++) begin
          j = i;
          while (j > 0 && ranks_ahead(routes[j], routes[j-1])) begin
            tmp = routes[j];
            routes[j] = routes[j-1];
            routes[j-1] = tmp;
            j--;
          end
        end
        if (n == 0) push_result(1'b0, 1'b0, '0, 1'b1);
        else pending_results[$].last = 1'b1;
      end
      OP_SWAP: begin
        near_n = 0;
        if (!c && route_cnt > 0) begin
          for (int i = 1; i < route_cnt; i++) begin
            d = routes[i].lat > routes[0].lat ? routes[i].lat - routes[0].lat
                                              : routes[0].lat - routes[i].lat;
            if (!(routes[i].hops <= routes[0].hops && d <= near_reg)) break;
            near_n++;
          end
          for (int i = 0; i < near_n; i++) begin
            tmp = routes[i];
            routes[i] = routes[i+1];
            routes[i+1] = tmp;
          end
        end
        push_result(near_n != 0, 1'b0, '0, 1'b1);
      end
      default: push_result(1'b0, 1'b0, '0, 1'b1);
    endcase
  endtask

  task automatic send_item(logic [2:0] op, logic [31:0] id, logic loc, logic [7:0] h,
                           logic [31:0] lat, logic [31:0] t, logic c);
    @(negedge clk);
    opcode <= op;
    peer_id <= id;
    peer_local <= loc;
    hop_count <= h;
    latency_us <= lat;
    now <= t;
    coin <= c;
    valid <= 1'b1;
    do @(posedge clk); while (!ready);
    predict_routes(op, id, loc, h, lat, t, c);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_reg = data[15:0];
    else near_reg = data;
  endtask

  // receiver stall pattern, mode changes now and then
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 150 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (stall_cnt % 5 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result flag=%0b full=%0b peer=%h last=%0b",
                 $realtime, flag, table_full, removed_peer, last);
        errors++;
      end else begin
        exp_r = pending_results[0];
        pending_results.delete(0);
        if (flag !== exp_r.flag) begin
          $display("%0t: flag expected %0b actual %0b", $realtime, exp_r.flag, flag);
          errors++;
        end
        if (table_full !== exp_r.table_full) begin
          $display("%0t: table_full expected %0b actual %0b", $realtime,
                   exp_r.table_full, table_full);
          errors++;
        end
        if (removed_peer !== exp_r.removed_peer) begin
          $display("%0t: removed_peer expected %h actual %h", $realtime,
                   exp_r.removed_peer, removed_peer);
          errors++;
        end
        if (last !== exp_r.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, exp_r.last, last);
          errors++;
        end
      end
    end
  end

  task automatic test_swap_empty();
    send_item(OP_SWAP, '0, 1'b0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_add();
    send_item(OP_ADD, 32'h0, 1'b0, 8'h00, 32'hffffffff, 32'd0, 1'b1);
    send_item(OP_ADD, 32'hffffffff, 1'b1, 8'hff, '0, 32'd100, 1'b0);
    send_item(OP_ADD, 32'h0, 1'b1, 8'h05, '0, 32'd50, 1'b0);
  endtask

  task automatic test_update();
    send_item(OP_UPDATE, 32'h1234, 1'b0, 8'd1, 32'd9, 32'd60, 1'b0);
    send_item(OP_UPDATE, 32'h0, 1'b0, 8'hc3, 32'hffffffff, 32'd61, 1'b0);
    send_item(OP_UPDATE, 32'h0, 1'b0, 8'hc4, 32'd20, 32'd62, 1'b0);
    send_item(OP_UPDATE, 32'h0, 1'b0, 8'h03, 32'd5, 32'd63, 1'b0);
  endtask

  task automatic test_delete();
    send_item(OP_ADD, 32'h7, 1'b0, 8'd2, '0, 32'd64, 1'b0);
    send_item(OP_DELETE, 32'h7, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_DELETE, 32'h7, 1'b0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_swap();
    send_item(OP_ADD, 32'h11, 1'b0, 8'd1, '0, 32'd70, 1'b0);
    send_item(OP_SWAP, '0, 1'b0, '0, '0, '0, 1'b1);
    send_item(OP_SWAP, '0, 1'b0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_cleanup();
    send_item(OP_CLEANUP, '0, 1'b0, '0, '0, 32'd10, 1'b0);
    send_item(OP_CLEANUP, '0, 1'b0, '0, '0, 32'hffffffff, 1'b0);
  endtask

  task automatic test_unused_ops();
    for (int op = 5; op < 8; op++)
      send_item(3'(op), 32'hffffffff, 1'b1, 8'hff, 32'hffffffff, 32'hffffffff, 1'b1);
  endtask

  // fill, refuse one, then a cleanup that reports most of the table and a second with nothing left to report
  task automatic test_full_table();
    int k;
    k = 0;
    while (route_cnt < NROUTES) begin
      send_item(OP_ADD, 32'h100 + k, 1'b0, 8'(k), '0, 32'd0, 1'b0);
      k++;
    end
    send_item(OP_ADD, 32'hdead, 1'b0, 8'd1, '0, 32'd0, 1'b0);
    send_item(OP_CLEANUP, '0, 1'b0, '0, '0, 32'd1000, 1'b0);
    send_item(OP_CLEANUP, '0, 1'b0, '0, '0, 32'd1000, 1'b0);
  endtask

  task automatic test_random(int count);
    int r, f;
    logic [2:0] op;
    logic [31:0] id, lat;
    logic [7:0] h;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      op = r < 35 ? OP_ADD : r < 55 ? OP_UPDATE : r < 65 ? OP_DELETE :
           r < 80 ? OP_CLEANUP : r < 96 ? OP_SWAP : 3'($urandom_range(5, 7));
      id = ($urandom_range(0, 9) == 0) ? $urandom : peer_pool[$urandom_range(0, POOL-1)];
      h = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6));
      f = find_route(id);
      if (f >= 0 && $urandom_range(0, 7) == 0)
        h = routes[f].hops + ($urandom_range(0, 1) ? HOP_SKIP_A : HOP_SKIP_B);
      lat = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30000);
      if ($urandom_range(0, 40) == 0) clock_now = $urandom;
      else clock_now += $urandom_range(0, 2 * timeout_reg);
      send_item(op, id, $urandom_range(0, 4) == 0, h, lat, clock_now, $urandom_range(0, 1));
    end
  endtask

  initial begin
    errors = 0;
    route_cnt = 0;
    timeout_reg = TIMEOUT_RESET;
    near_reg = NEAR_RESET;
    burst_left = 4;
    clock_now = 0;
    for (int i = 0; i < POOL; i++) peer_pool[i] = $urandom;
    peer_pool[0] = 32'h0;
    peer_pool[1] = 32'hffffffff;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_swap_empty();
    test_add();
    test_update();
    test_delete();
    test_swap();
    test_cleanup();
    test_unused_ops();
    test_full_table();
    drain_results();

    test_random(90);
    drain_results();
    write_reg(CFG_TIMEOUT, 32'd1);
    write_reg(CFG_NEAR, 32'd0);
    test_random(90);
    drain_results();
    write_reg(CFG_TIMEOUT, 32'hffffffff);
    write_reg(CFG_NEAR, 32'hffffffff);
    test_random(90);
    drain_results();
    write_reg(CFG_TIMEOUT, $urandom_range(2, 200));
    write_reg(CFG_NEAR, $urandom_range(0, 20000));
    test_random(90);
    drain_results();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
